/* rtl/scp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Shared widths and fixed-point constants of the sine/cosine polynomial core.
// ----------------------------------------------------------------------------
package scp_pkg;

  // Internal words are signed with QF fraction bits, QW bits wide.
  localparam int QF = 40;
  localparam int QW = 44;
  // Width of the wide difference taken during range reduction.
  localparam int LW = 64;

  // Default fraction bits of the ports.
  localparam int ANGLE_FRAC_BITS_DEF  = 24;
  localparam int RESULT_FRAC_BITS_DEF = 30;

  // Circle constants in Q40.
  localparam logic signed [QW-1:0] TWO_PI_Q  = 44'sh6487ED5110B;
  localparam logic signed [QW-1:0] PI_Q      = 44'sh3243F6A8886;
  localparam logic signed [QW-1:0] HALF_PI_Q = 44'sh1921FB54443;
  localparam logic signed [QW-1:0] ONE_Q     = 44'sh10000000000;
  localparam logic signed [QW-1:0] ZERO_Q    = '0;

  // Reciprocal of 2*pi scaled by 2^RECIP_SHIFT, for the quotient estimate.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 19;
  localparam logic signed [RECIP_W-1:0] RECIP_2PI = 19'sd166886;

  // Horner coefficients: leading term and the addend of each of five steps.
  localparam logic signed [QW-1:0] COS_TOP = -44'sd286441;
  localparam logic signed [QW-1:0] COS_ADD [5] = '{
    44'sd27224452, -44'sd1527043273, 44'sd45812953923, -44'sd549755808486,
    ONE_Q
  };
  localparam logic signed [QW-1:0] SIN_TOP = -44'sd26200;
  localparam logic signed [QW-1:0] SIN_ADD [5] = '{
    44'sd3026027, -44'sd218151710, 44'sd9162593583, -44'sd183251937249,
    ONE_Q
  };

endpackage

/* rtl/scp_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_mac
// Three-stage Q40 multiply-add: p = round(a*b) + c, products rounded to
// nearest with ties away from zero, built from four narrow partial products.
// ----------------------------------------------------------------------------
module scp_mac (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [scp_pkg::QW-1:0]  a_i,
  input  logic signed [scp_pkg::QW-1:0]  b_i,
  input  logic signed [scp_pkg::QW-1:0]  c_i,
  output logic signed [scp_pkg::QW-1:0]  p_o
);

  localparam int QW = scp_pkg::QW;
  localparam int QF = scp_pkg::QF;
  localparam int HW = QW / 2;
  localparam int SW = 2 * QW;

  logic [QW-1:0]          ma, mb;
  logic [2*HW-1:0]        ll_q, lh_q, hl_q, hh_q;
  logic                   neg_a_q, neg_b_q;
  logic signed [QW-1:0]   c_a_q, c_b_q, p_q;
  logic [SW-1:0]          sum;
  logic [QW-1:0]          m_q;

  // Operand magnitudes.
  always_comb begin
    ma = a_i[QW-1] ? QW'(-a_i) : QW'(a_i);
    mb = b_i[QW-1] ? QW'(-b_i) : QW'(b_i);
  end

  // Sum of the shifted partial products plus the rounding half.
  always_comb begin
    sum = SW'(ll_q) + (SW'(lh_q) << HW) + (SW'(hl_q) << HW) + (SW'(hh_q) << QW)
        + (SW'(1) << (QF - 1));
  end

  // Stage A partial products, stage B rounded magnitude, stage C signed add.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q    <= ma[HW-1:0] * mb[HW-1:0];
      lh_q    <= ma[HW-1:0] * mb[QW-1:HW];
      hl_q    <= ma[QW-1:HW] * mb[HW-1:0];
      hh_q    <= ma[QW-1:HW] * mb[QW-1:HW];
      neg_a_q <= a_i[QW-1] ^ b_i[QW-1];
      c_a_q   <= c_i;
      m_q     <= sum[QF +: QW];
      neg_b_q <= neg_a_q;
      c_b_q   <= c_a_q;
      p_q     <= neg_b_q ? c_b_q - $signed(m_q) : c_b_q + $signed(m_q);
    end
  end

  assign p_o = p_q;

endmodule

/* rtl/sine_cosine_polynomial_core.sv */
`timescale 1ns / 1ps
// Throughput: one angle per cycle while the output does not stall, set by the
// fully pipelined reduction and multiply-add chain.
// A stall on the output holds the whole pipeline in place.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// sine_cosine_polynomial_core
// Reduces an angle to [-pi/2, pi/2] and evaluates sine and cosine polynomials.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial_core #(
  parameter int ANGLE_FRAC_BITS  = scp_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int RESULT_FRAC_BITS = scp_pkg::RESULT_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] sine_value_o,
  output logic signed [31:0] cosine_value_o
);

  localparam int QW    = scp_pkg::QW;
  localparam int QF    = scp_pkg::QF;
  localparam int LW    = scp_pkg::LW;
  localparam int DEPTH = 28;
  localparam int PW1   = 32 + scp_pkg::RECIP_W;
  localparam int SHQ   = ANGLE_FRAC_BITS + scp_pkg::RECIP_SHIFT;
  localparam int KW    = PW1 - SHQ;
  localparam int BW    = 32 + QF - ANGLE_FRAC_BITS;
  localparam int PRW   = KW + QW;
  localparam int RW    = QW + 1;
  localparam int SH    = QF - RESULT_FRAC_BITS;

  logic                  en;
  logic [DEPTH-1:0]      valid_q;

  logic signed [PW1-1:0] p1_q;
  logic signed [BW-1:0]  big1_q, big2_q;
  logic signed [KW-1:0]  k;
  logic signed [PRW-1:0] prod2_q;
  logic signed [LW-1:0]  diff;
  logic signed [RW-1:0]  r3_q;
  logic signed [RW:0]    r3x2;
  logic signed [QW-1:0]  r4_q, x5_q;
  logic                  flip5_q;

  logic signed [QW-1:0]  x2;
  logic signed [QW-1:0]  x2_line [12];
  logic signed [QW-1:0]  x2_tap  [5];
  logic signed [QW-1:0]  x_line  [18];
  logic                  flip_line [21];
  logic signed [QW-1:0]  cos_line [3];
  logic signed [QW-1:0]  cos_acc [6];
  logic signed [QW-1:0]  sin_acc [6];
  logic signed [QW-1:0]  sin_p;

  logic [QW-1:0]         sm_q, cm_q;
  logic                  sneg_q, cneg_q;
  logic signed [31:0]    sine_q, cosine_q;

  // Rounded magnitude of a Q40 value at the result fraction width.
  function automatic logic [QW-1:0] rnd_mag(input logic signed [QW-1:0] v);
    logic [QW-1:0] m;
    m = v[QW-1] ? QW'(-v) : QW'(v);
    return (m + (QW'(1) << (SH - 1))) >> SH;
  endfunction

  // Clamp to one and restore the sign.
  function automatic logic signed [31:0] sat_out(input logic [QW-1:0] m,
                                                 input logic neg);
    logic [QW-1:0] lim;
    logic [QW-1:0] c;
    lim = QW'(1) << RESULT_FRAC_BITS;
    c   = (m > lim) ? lim : m;
    return neg ? -$signed(32'(c)) : $signed(32'(c));
  endfunction

  // The pipeline advances whenever the output register is free or drains.
  assign en         = !valid_q[DEPTH-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[DEPTH-2:0], in_valid_i};
    end
  end

  // Quotient estimate, correction and reflection.
  always_comb begin
    k    = KW'((p1_q + (PW1'(1) <<< (SHQ - 1))) >>> SHQ);
    diff = LW'(big2_q) - LW'(prod2_q);
    r3x2 = {r3_q, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q    <= PW1'(angle_i) * PW1'(scp_pkg::RECIP_2PI);
      big1_q  <= BW'(angle_i) <<< (QF - ANGLE_FRAC_BITS);
      prod2_q <= PRW'(k) * PRW'(scp_pkg::TWO_PI_Q);
      big2_q  <= big1_q;
      r3_q    <= diff[RW-1:0];
      if (r3x2 > (RW + 1)'(scp_pkg::TWO_PI_Q)) begin
        r4_q <= QW'(r3_q - RW'(scp_pkg::TWO_PI_Q));
      end else if (r3x2 < -(RW + 1)'(scp_pkg::TWO_PI_Q)) begin
        r4_q <= QW'(r3_q + RW'(scp_pkg::TWO_PI_Q));
      end else begin
        r4_q <= QW'(r3_q);
      end
      if (r4_q > scp_pkg::HALF_PI_Q) begin
        x5_q    <= scp_pkg::PI_Q - r4_q;
        flip5_q <= 1'b1;
      end else if (r4_q < -scp_pkg::HALF_PI_Q) begin
        x5_q    <= -scp_pkg::PI_Q - r4_q;
        flip5_q <= 1'b1;
      end else begin
        x5_q    <= r4_q;
        flip5_q <= 1'b0;
      end
    end
  end

  // Square of the reduced angle.
  scp_mac u_mac_x2 (
    .clk_i (clk_i), .en_i (en), .a_i (x5_q), .b_i (x5_q),
    .c_i (scp_pkg::ZERO_Q), .p_o (x2)
  );

  // Delay lines that keep x, x^2, the reflection flag and cosine aligned.
  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_line[0]   <= x2;
      x_line[0]    <= x5_q;
      flip_line[0] <= flip5_q;
      cos_line[0]  <= cos_acc[5];
      for (int i = 1; i < 12; i++) x2_line[i] <= x2_line[i-1];
      for (int i = 1; i < 18; i++) x_line[i] <= x_line[i-1];
      for (int i = 1; i < 21; i++) flip_line[i] <= flip_line[i-1];
      for (int i = 1; i < 3; i++) cos_line[i] <= cos_line[i-1];
    end
  end

  assign cos_acc[0] = scp_pkg::COS_TOP;
  assign sin_acc[0] = scp_pkg::SIN_TOP;

  // Horner steps in x^2 for both polynomials.
  for (genvar i = 0; i < 5; i++) begin : g_horner
    if (i == 0) begin : g_tap0
      assign x2_tap[i] = x2;
    end else begin : g_tapn
      assign x2_tap[i] = x2_line[3*i-1];
    end
    scp_mac u_mac_cos (
      .clk_i (clk_i), .en_i (en), .a_i (cos_acc[i]), .b_i (x2_tap[i]),
      .c_i (scp_pkg::COS_ADD[i]), .p_o (cos_acc[i+1])
    );
    scp_mac u_mac_sin (
      .clk_i (clk_i), .en_i (en), .a_i (sin_acc[i]), .b_i (x2_tap[i]),
      .c_i (scp_pkg::SIN_ADD[i]), .p_o (sin_acc[i+1])
    );
  end

  // Final sine factor of x.
  scp_mac u_mac_sx (
    .clk_i (clk_i), .en_i (en), .a_i (sin_acc[5]), .b_i (x_line[17]),
    .c_i (scp_pkg::ZERO_Q), .p_o (sin_p)
  );

  // Rounding, then saturation into the output register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sm_q     <= rnd_mag(sin_p);
      sneg_q   <= sin_p[QW-1];
      cm_q     <= rnd_mag(cos_line[2]);
      cneg_q   <= cos_line[2][QW-1] ^ flip_line[20];
      sine_q   <= sat_out(sm_q, sneg_q);
      cosine_q <= sat_out(cm_q, cneg_q);
    end
  end

  assign out_valid_o    = valid_q[DEPTH-1];
  assign sine_value_o   = sine_q;
  assign cosine_value_o = cosine_q;

endmodule

/* rtl/scp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks of the sine/cosine core, bound to the top level.
// ----------------------------------------------------------------------------
module scp_checker #(
  parameter int RESULT_FRAC_BITS = scp_pkg::RESULT_FRAC_BITS_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic signed [31:0] angle_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] sine_value_o,
  input logic signed [31:0] cosine_value_o
);

  localparam logic signed [31:0] LIM = 32'sd1 <<< RESULT_FRAC_BITS;

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sine_value_o)
      && $stable(cosine_value_o))
    else $error("stalled result changed");

  // Results never exceed one in magnitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sine_value_o <= LIM && sine_value_o >= -LIM
      && cosine_value_o <= LIM && cosine_value_o >= -LIM)
    else $error("result beyond saturation limit");

  // With no result waiting, the core takes input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // A result transfer frees the pipeline for a new angle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input blocked during result transfer");

endmodule

bind sine_cosine_polynomial_core scp_checker #(
  .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
) u_scp_checker (.*);

/* tb/sv/sine_cosine_polynomial_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_polynomial_core_test
// Drives angles into the sine/cosine core under random idling and stalls on
// both sides, and checks every result against a fixed-point predictor or a stored pair.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial_core_test;

  localparam int    NUM_RANDOM = 1730;
  localparam int    SETTLE     = 40;
  localparam longint TWO_PI_FX  = 64'sh6487ED5110B;
  localparam longint PI_FX      = 64'sh3243F6A8886;
  localparam longint HALF_PI_FX = 64'sh1921FB54443;
  localparam longint ONE_FX     = 64'sh10000000000;

  typedef struct packed {
    logic signed [31:0] sine;
    logic signed [31:0] cosine;
  } trig_pair_t;

  typedef struct {
    logic signed [31:0] angle;
    bit                 known;
    trig_pair_t         pair;
  } angle_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] angle_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] sine_value_o;
  logic signed [31:0] cosine_value_o;

  trig_pair_t pending_pairs[$];
  int         num_errors;
  longint     cycle_count;
  bit         sending_done;

  longint cos_terms[5] = '{
    -64'sd549755808486, 64'sd45812953923, -64'sd1527043273, 64'sd27224452,
    -64'sd286441
  };
  longint sin_terms[5] = '{
    -64'sd183251937249, 64'sd9162593583, -64'sd218151710, 64'sd3026027,
    -64'sd26200
  };

  sine_cosine_polynomial_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .angle_i       (angle_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sine_value_o  (sine_value_o),
    .cosine_value_o(cosine_value_o)
  );

  // Q40 product, rounded to nearest with ties away from zero.
  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] ma, mb, prod;
    bit           neg;
    neg  = (a < 0) != (b < 0);
    ma   = (a < 0) ? -a : a;
    mb   = (b < 0) ? -b : b;
    prod = (ma * mb + (128'd1 << 39)) >> 40;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // Q40 to Q30 with rounding and saturation to +-1.
  function automatic logic signed [31:0] fx_to_port(longint v);
    longint m;
    m = (((v < 0) ? -v : v) + 512) >>> 10;
    if (m > (64'sd1 << 30)) m = 64'sd1 << 30;
    return (v < 0) ? 32'(-m) : 32'(m);
  endfunction

  function automatic trig_pair_t sincos_of_angle(logic signed [31:0] ang);
    longint     wide, rem, x, x2, acc_c, acc_s;
    bit         flip;
    trig_pair_t res;
    wide = longint'(ang) * 65536;
    rem  = wide % TWO_PI_FX;
    if (2 * rem > TWO_PI_FX) rem -= TWO_PI_FX;
    else if (2 * rem < -TWO_PI_FX) rem += TWO_PI_FX;
    flip = 1'b1;
    if (rem > HALF_PI_FX) x = PI_FX - rem;
    else if (rem < -HALF_PI_FX) x = -PI_FX - rem;
    else begin
      x    = rem;
      flip = 1'b0;
    end
    x2    = fx_mul(x, x);
    acc_c = cos_terms[4];
    acc_s = sin_terms[4];
    for (int i = 3; i >= 0; i--) begin
      acc_c = fx_mul(acc_c, x2) + cos_terms[i];
      acc_s = fx_mul(acc_s, x2) + sin_terms[i];
    end
    acc_c = fx_mul(acc_c, x2) + ONE_FX;
    acc_s = fx_mul(fx_mul(acc_s, x2) + ONE_FX, x);
    if (flip) acc_c = -acc_c;
    res.sine   = fx_to_port(acc_s);
    res.cosine = fx_to_port(acc_c);
    return res;
  endfunction

  // Directed angles: zero, extremes, quadrant edges and multiples of pi.
  angle_row_t directed_rows[] = '{
    '{32'sd0,          1'b1, '{32'sd0, 32'sd1073741824}},
    '{32'sh7FFFFFFF,   1'b0, '{32'sd0, 32'sd0}},
    '{-32'sh80000000,  1'b0, '{32'sd0, 32'sd0}},
    '{32'sd1,          1'b0, '{32'sd0, 32'sd0}},
    '{-32'sd1,         1'b0, '{32'sd0, 32'sd0}},
    '{32'sd26353589,   1'b0, '{32'sd0, 32'sd0}},
    '{32'sd26353590,   1'b0, '{32'sd0, 32'sd0}},
    '{-32'sd26353589,  1'b0, '{32'sd0, 32'sd0}},
    '{-32'sd26353590,  1'b0, '{32'sd0, 32'sd0}},
    '{32'sd52707179,   1'b0, '{32'sd0, 32'sd0}},
    '{-32'sd52707179,  1'b0, '{32'sd0, 32'sd0}},
    '{32'sd52707180,   1'b0, '{32'sd0, 32'sd0}},
    '{32'sd105414357,  1'b0, '{32'sd0, 32'sd0}},
    '{-32'sd105414357, 1'b0, '{32'sd0, 32'sd0}},
    '{32'sd158121536,  1'b0, '{32'sd0, 32'sd0}},
    '{32'sd79060768,   1'b0, '{32'sd0, 32'sd0}},
    '{-32'sd79060768,  1'b0, '{32'sd0, 32'sd0}},
    '{32'sd16777216,   1'b0, '{32'sd0, 32'sd0}},
    '{32'sh55555555,   1'b0, '{32'sd0, 32'sd0}},
    '{-32'sh2AAAAAAB,  1'b0, '{32'sd0, 32'sd0}}
  };

  // Clock and the single reset at the start.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Offer one angle and hold it until the transfer, then queue its result.
  task automatic send_angle(logic signed [31:0] ang, bit known, trig_pair_t pair);
    in_valid_i <= 1'b1;
    angle_i    <= ang;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pairs.push_back(known ? pair : sincos_of_angle(ang));
  endtask

  // Random idle gap; item indexes in the quiet window never idle.
  task automatic sender_gap(int idx);
    if (idx >= 600 && idx < 900) return;
    if ($urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Sender process.
  initial begin
    logic signed [31:0] ang;
    in_valid_i   = 1'b0;
    angle_i      = '0;
    num_errors   = 0;
    cycle_count  = 0;
    sending_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      sender_gap(i);
      send_angle(directed_rows[i].angle, directed_rows[i].known, directed_rows[i].pair);
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      // Pause the source until the pipeline has drained completely.
      if (n == 1200) begin
        in_valid_i <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end else begin
        sender_gap(n);
      end
      case ($urandom_range(3))
        0, 1:    ang = $urandom;
        2:       ang = 32'($signed($urandom_range(210828714)) - 105414357);
        default: ang = 32'($signed($urandom_range(2048)) - 1024);
      endcase
      send_angle(ang, 1'b0, '0);
    end
    in_valid_i   <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off, and a quiet stretch.
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (cycle_count >= 300 && cycle_count < 320) begin
        out_ready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (cycle_count >= 1000 && cycle_count < 1400) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 11);
      end
    end
  end

  // Check each result transfer against the oldest expected pair.
  always @(posedge clk_i) begin
    trig_pair_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pairs.size() == 0) begin
        $error("result transfer with nothing expected: sine %0d cosine %0d",
               sine_value_o, cosine_value_o);
        num_errors++;
      end else begin
        want = pending_pairs.pop_front();
        if (sine_value_o !== want.sine) begin
          $error("sine_value: expected %0d, actual %0d", want.sine, sine_value_o);
          num_errors++;
        end
        if (cosine_value_o !== want.cosine) begin
          $error("cosine_value: expected %0d, actual %0d", want.cosine, cosine_value_o);
          num_errors++;
        end
      end
    end
  end

  // End of run once every expected result has come back.
  initial begin
    wait (sending_done);
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (num_errors == 0 && pending_pairs.size() == 0) begin
      $display("** sine_cosine_polynomial_core: PASSED **");
    end else begin
      $display("** sine_cosine_polynomial_core: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("** sine_cosine_polynomial_core: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
rtl/scp_pkg.sv
rtl/scp_mac.sv
rtl/sine_cosine_polynomial_core.sv
rtl/scp_checker.sv
tb/sv/sine_cosine_polynomial_core_test.sv
